// File: hw/rtl/pup_pkg.sv
package pup_pkg;

    // Default pool depth.
    localparam int POOL_SIZE_DEF = 64;

    // Fixed field widths.
    localparam int DT_W    = 16;
    localparam int POS_W   = 32;
    localparam int LIFE_W  = 24;
    localparam int SIZE_W  = 16;
    localparam int COL_W   = 8;
    localparam int ALIVE_W = 7;
    localparam int T_W     = 16;

    // Number of interpolated values per particle: width, height and four channels.
    localparam int LERP_N  = 6;

    // Action codes on the command input.
    typedef enum logic [1:0] {
        ACT_EMIT  = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // One pool entry as it sits in the slot memory.
    typedef struct packed {
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [POS_W-1:0]  vel_x;
        logic [POS_W-1:0]  vel_y;
        logic [LIFE_W-1:0] life_total;
        logic [LIFE_W-1:0] life_left;
        logic [63:0]       size_pair;
        logic [63:0]       colour_pair;
    } t_entry;

endpackage

// File: hw/rtl/particle_pool_update.sv
// Emit and clear commands complete while idle; busy stays low for them.
// A tick walks every slot in order: an inactive slot is only scanned, an expiring slot is
// read and dropped, and a live slot takes a memory read, a 16-step bit-serial divider for t,
// one multiply stage and one write-back; a closing step then flushes the last result.
// Results leave one live particle behind the walk; the receiver cannot stall.
// Synchronous active-low reset clears the active flags, ring index and control.
module particle_pool_update
    import pup_pkg::*;
#(
    parameter int POOL_SIZE = POOL_SIZE_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_action,
    input  logic [DT_W-1:0]          i_delta_time,
    input  logic signed [POS_W-1:0]  i_pos_x,
    input  logic signed [POS_W-1:0]  i_pos_y,
    input  logic signed [POS_W-1:0]  i_vel_x,
    input  logic signed [POS_W-1:0]  i_vel_y,
    input  logic [LIFE_W-1:0]        i_life_span,
    input  logic [31:0]              i_size_start,
    input  logic [31:0]              i_size_final,
    input  logic [31:0]              i_colour_start,
    input  logic [31:0]              i_colour_final,
    output logic                     o_result_strobe,
    output logic                     o_quad_valid,
    output logic                     o_last_quad,
    output logic signed [POS_W-1:0]  o_centre_x,
    output logic signed [POS_W-1:0]  o_centre_y,
    output logic [SIZE_W-1:0]        o_half_w,
    output logic [SIZE_W-1:0]        o_half_h,
    output logic [COL_W-1:0]         o_red,
    output logic [COL_W-1:0]         o_green,
    output logic [COL_W-1:0]         o_blue,
    output logic [COL_W-1:0]         o_alpha,
    output logic [ALIVE_W-1:0]       o_alive_total
);

    localparam int IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(POOL_SIZE - 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_LOAD = 6'b000100,
        S_DIV  = 6'b001000,
        S_MUL  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    // Slot memory with registered read data.
    t_entry r_slot_mem [POOL_SIZE];
    t_entry r_rd;

    t_state                  r_state;
    logic                    r_fin;
    logic [IW-1:0]           r_idx;
    logic [IW-1:0]           r_ring;
    logic [POOL_SIZE-1:0]    r_act;
    logic [DT_W-1:0]         r_dt;
    t_entry                  r_ent;
    logic [LIFE_W-1:0]       r_left;
    logic signed [48:0]      r_px;
    logic signed [48:0]      r_py;
    logic [LIFE_W:0]         r_rem;
    logic [T_W-1:0]          r_quo;
    logic [3:0]              r_step;
    logic signed [33:0]      r_lp [LERP_N];
    logic [POS_W-1:0]        r_cx;
    logic [POS_W-1:0]        r_cy;
    logic [ALIVE_W-1:0]      r_cnt;
    logic                    r_have;

    // Pending result, held until the next live particle or the end of the walk.
    logic [POS_W-1:0]        r_p_cx;
    logic [POS_W-1:0]        r_p_cy;
    logic [SIZE_W-1:0]       r_p_hw;
    logic [SIZE_W-1:0]       r_p_hh;
    logic [COL_W-1:0]        r_p_col [4];
    logic [ALIVE_W-1:0]      r_p_cnt;

    // Output registers.
    logic                    r_o_stb;
    logic                    r_o_valid;
    logic                    r_o_last;
    logic [POS_W-1:0]        r_o_cx;
    logic [POS_W-1:0]        r_o_cy;
    logic [SIZE_W-1:0]       r_o_hw;
    logic [SIZE_W-1:0]       r_o_hh;
    logic [COL_W-1:0]        r_o_col [4];
    logic [ALIVE_W-1:0]      r_o_cnt;

    logic                    accept;
    logic                    mem_we;
    logic [IW-1:0]           mem_wa;
    t_entry                  mem_wd;
    logic [SIZE_W-1:0]       la [LERP_N];
    logic [SIZE_W-1:0]       lb [LERP_N];
    logic [SIZE_W-1:0]       lv [LERP_N];
    logic [LIFE_W:0]         div_sh;
    logic                    div_bit;
    logic signed [33:0]      sum_x;
    logic signed [33:0]      sum_y;
    logic [POS_W-1:0]        sat_x;
    logic [POS_W-1:0]        sat_y;

    assign busy   = (r_state != S_IDLE) || r_fin;
    assign accept = start && !busy;

    // Lerp endpoints taken apart from the stored pairs.
    always_comb begin
        la[0] = r_ent.size_pair[63:48];
        lb[0] = r_ent.size_pair[31:16];
        la[1] = r_ent.size_pair[47:32];
        lb[1] = r_ent.size_pair[15:0];
        for (int k = 0; k < 4; k++) begin
            la[k+2] = {8'd0, r_ent.colour_pair[63-8*k -: 8]};
            lb[k+2] = {8'd0, r_ent.colour_pair[31-8*k -: 8]};
        end
        for (int k = 0; k < LERP_N; k++) begin
            lv[k] = la[k] + r_lp[k][31:16];
        end
    end

    // One restoring divider step; the remainder stays below the lifetime.
    always_comb begin
        div_sh  = {r_rem[LIFE_W-1:0], 1'b0};
        div_bit = div_sh >= {1'b0, r_ent.life_total};
    end

    // Position step with saturation to the signed 32-bit range.
    always_comb begin
        sum_x = {{2{r_ent.pos_x[31]}}, r_ent.pos_x} + {r_px[48], r_px[48:16]};
        sum_y = {{2{r_ent.pos_y[31]}}, r_ent.pos_y} + {r_py[48], r_py[48:16]};
        if (sum_x[33:31] == 3'b000 || sum_x[33:31] == 3'b111) begin
            sat_x = sum_x[31:0];
        end else begin
            sat_x = sum_x[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        if (sum_y[33:31] == 3'b000 || sum_y[33:31] == 3'b111) begin
            sat_y = sum_y[31:0];
        end else begin
            sat_y = sum_y[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    end

    // Memory write port: emits in idle, write-back at the end of a live slot.
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_ring;
        mem_wd = r_ent;
        if (accept && i_action == ACT_EMIT) begin
            mem_we             = 1'b1;
            mem_wd.pos_x       = i_pos_x;
            mem_wd.pos_y       = i_pos_y;
            mem_wd.vel_x       = i_vel_x;
            mem_wd.vel_y       = i_vel_y;
            mem_wd.life_total  = i_life_span;
            mem_wd.life_left   = i_life_span;
            mem_wd.size_pair   = {i_size_start, i_size_final};
            mem_wd.colour_pair = {i_colour_start, i_colour_final};
        end else if (r_state == S_OUT) begin
            mem_we           = 1'b1;
            mem_wa           = r_idx;
            mem_wd.life_left = r_left;
            mem_wd.pos_x     = r_cx;
            mem_wd.pos_y     = r_cy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_slot_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_slot_mem[r_idx];
    end

    // Walk sequencer and result path.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fin   <= 1'b0;
            r_idx   <= '0;
            r_ring  <= '0;
            r_act   <= '0;
            r_have  <= 1'b0;
            r_cnt   <= '0;
            r_o_stb <= 1'b0;
        end else begin
            r_o_stb <= 1'b0;
            r_fin   <= 1'b0;

            // Closing cycle of a tick: flush the held result, or an empty one if none is held, as the last one.
            if (r_fin) begin
                r_o_stb   <= 1'b1;
                r_o_last  <= 1'b1;
                r_o_valid <= r_have;
                r_o_cx    <= r_have ? r_p_cx  : '0;
                r_o_cy    <= r_have ? r_p_cy  : '0;
                r_o_hw    <= r_have ? r_p_hw  : '0;
                r_o_hh    <= r_have ? r_p_hh  : '0;
                r_o_cnt   <= r_have ? r_p_cnt : '0;
                for (int k = 0; k < 4; k++) begin
                    r_o_col[k] <= r_have ? r_p_col[k] : '0;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (t_action'(i_action))
                            ACT_EMIT: begin
                                r_act[r_ring] <= 1'b1;
                                r_ring <= (r_ring == LAST_IDX) ? '0 : r_ring + 1'b1;
                            end
                            ACT_CLEAR: begin
                                r_act <= '0;
                            end
                            ACT_TICK: begin
                                r_dt    <= i_delta_time;
                                r_idx   <= '0;
                                r_cnt   <= '0;
                                r_have  <= 1'b0;
                                r_state <= S_SCAN;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_act[r_idx]) begin
                        r_state <= S_LOAD;
                    end else if (r_idx == LAST_IDX) begin
                        r_fin   <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_LOAD: begin
                    r_ent <= r_rd;
                    if (r_rd.life_left <= {8'd0, r_dt}) begin
                        // Expired particle: drop it and move on.
                        r_act[r_idx] <= 1'b0;
                        if (r_idx == LAST_IDX) begin
                            r_fin   <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_SCAN;
                        end
                    end else begin
                        r_left  <= r_rd.life_left - {8'd0, r_dt};
                        r_px    <= $signed(r_rd.vel_x) * $signed({1'b0, r_dt});
                        r_py    <= $signed(r_rd.vel_y) * $signed({1'b0, r_dt});
                        r_rem   <= {1'b0, r_rd.life_total - (r_rd.life_left - {8'd0, r_dt})};
                        r_quo   <= '0;
                        r_step  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= div_bit ? div_sh - {1'b0, r_ent.life_total} : div_sh;
                    r_quo  <= {r_quo[T_W-2:0], div_bit};
                    r_step <= r_step + 1'b1;
                    if (r_step == 4'd15) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    for (int k = 0; k < LERP_N; k++) begin
                        r_lp[k] <= ($signed({1'b0, lb[k]}) - $signed({1'b0, la[k]}))
                                   * $signed({1'b0, r_quo});
                    end
                    r_cx    <= sat_x;
                    r_cy    <= sat_y;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // Release the previous live result, then hold this one.
                    if (r_have) begin
                        r_o_stb   <= 1'b1;
                        r_o_valid <= 1'b1;
                        r_o_last  <= 1'b0;
                        r_o_cx    <= r_p_cx;
                        r_o_cy    <= r_p_cy;
                        r_o_hw    <= r_p_hw;
                        r_o_hh    <= r_p_hh;
                        r_o_cnt   <= r_p_cnt;
                        for (int k = 0; k < 4; k++) begin
                            r_o_col[k] <= r_p_col[k];
                        end
                    end
                    r_have  <= 1'b1;
                    r_p_cx  <= r_cx;
                    r_p_cy  <= r_cy;
                    r_p_hw  <= {1'b0, lv[0][SIZE_W-1:1]};
                    r_p_hh  <= {1'b0, lv[1][SIZE_W-1:1]};
                    for (int k = 0; k < 4; k++) begin
                        r_p_col[k] <= lv[k+2][COL_W-1:0];
                    end
                    r_p_cnt <= r_cnt + 1'b1;
                    r_cnt   <= r_cnt + 1'b1;
                    if (r_idx == LAST_IDX) begin
                        r_fin   <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SCAN;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result_strobe = r_o_stb;
    assign o_quad_valid    = r_o_valid;
    assign o_last_quad     = r_o_last;
    assign o_centre_x      = r_o_cx;
    assign o_centre_y      = r_o_cy;
    assign o_half_w        = r_o_hw;
    assign o_half_h        = r_o_hh;
    assign o_red           = r_o_col[0];
    assign o_green         = r_o_col[1];
    assign o_blue          = r_o_col[2];
    assign o_alpha         = r_o_col[3];
    assign o_alive_total   = r_o_cnt;

`ifndef SYNTHESIS
    // An empty-tick result is always the closing one.
    a_invalid_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe && !o_quad_valid |-> o_last_quad)
        else $error("invalid result not marked last");

    // A live quad always carries a nonzero running count.
    a_live_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe && o_quad_valid |-> o_alive_total != '0)
        else $error("live quad with zero count");

    // Results only come out of a walk that was running the cycle before.
    a_strobe_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(busy))
        else $error("result outside a tick");

    // An accepted tick always raises busy on the next cycle.
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_action == ACT_TICK |=> busy)
        else $error("tick did not start a walk");
`endif

endmodule

// File: dv/tb.sv
module tb;
    import pup_pkg::*;

    localparam int POOL = 64;
    localparam int CYCLE_LIMIT = 2000000;

    // One quad as it leaves the block.
    typedef struct packed {
        logic                    quad_valid;
        logic                    last_quad;
        logic signed [31:0]      centre_x;
        logic signed [31:0]      centre_y;
        logic [15:0]             half_w;
        logic [15:0]             half_h;
        logic [7:0]              red;
        logic [7:0]              green;
        logic [7:0]              blue;
        logic [7:0]              alpha;
        logic [6:0]              alive_total;
    } t_quad;

    // Pool predictor and the queue of quads it expects.
    class quad_scoreboard;
        bit                 live [POOL];
        longint             px [POOL];
        longint             py [POOL];
        longint             vx [POOL];
        longint             vy [POOL];
        longint             life_all [POOL];
        longint             life_rest [POOL];
        logic [63:0]        sizes [POOL];
        logic [63:0]        colours [POOL];
        int                 ring;
        t_quad              pending [$];
        int                 errors;

        function longint floor_div16(longint p);
            if (p >= 0) return p / 65536;
            return -((-p + 65535) / 65536);
        endfunction

        function longint step_pos(longint p, longint v, longint dt);
            longint s;
            s = p + floor_div16(v * dt);
            if (s > 64'sd2147483647) s = 64'sd2147483647;
            if (s < -64'sd2147483648) s = -64'sd2147483648;
            return s;
        endfunction

        function longint blend(longint a, longint b, longint t);
            return a + floor_div16((b - a) * t);
        endfunction

        // Note one accepted command and queue the quads it causes.
        function void note_command(t_action act, logic [15:0] dt, logic [31:0] x,
                                   logic [31:0] y, logic [31:0] vxi, logic [31:0] vyi,
                                   logic [23:0] life, logic [31:0] s0, logic [31:0] s1,
                                   logic [31:0] c0, logic [31:0] c1);
            int n;
            longint t, w, h;
            t_quad q;
            n = 0;
            case (act)
                ACT_EMIT: begin
                    live[ring] = 1;
                    px[ring] = longint'(signed'(x));
                    py[ring] = longint'(signed'(y));
                    vx[ring] = longint'(signed'(vxi));
                    vy[ring] = longint'(signed'(vyi));
                    life_all[ring] = life;
                    life_rest[ring] = life;
                    sizes[ring] = {s0, s1};
                    colours[ring] = {c0, c1};
                    ring = (ring + 1) % POOL;
                end
                ACT_CLEAR: begin
                    foreach (live[i]) live[i] = 0;
                end
                ACT_TICK: begin
                    for (int i = 0; i < POOL; i++) begin
                        if (!live[i]) continue;
                        if (life_rest[i] <= dt) begin
                            live[i] = 0;
                            continue;
                        end
                        life_rest[i] -= dt;
                        px[i] = step_pos(px[i], vx[i], dt);
                        py[i] = step_pos(py[i], vy[i], dt);
                        t = ((life_all[i] - life_rest[i]) << 16) / life_all[i];
                        w = blend(sizes[i][63:48], sizes[i][31:16], t);
                        h = blend(sizes[i][47:32], sizes[i][15:0], t);
                        q = '0;
                        q.quad_valid = 1;
                        q.centre_x = px[i][31:0];
                        q.centre_y = py[i][31:0];
                        q.half_w = w[16:1];
                        q.half_h = h[16:1];
                        q.red = 8'(blend(colours[i][63:56], colours[i][31:24], t));
                        q.green = 8'(blend(colours[i][55:48], colours[i][23:16], t));
                        q.blue = 8'(blend(colours[i][47:40], colours[i][15:8], t));
                        q.alpha = 8'(blend(colours[i][39:32], colours[i][7:0], t));
                        n++;
                        q.alive_total = 7'(n);
                        pending = {pending, q};
                    end
                    if (n == 0) begin
                        q = '0;
                        q.last_quad = 1;
                        pending = {pending, q};
                    end else begin
                        pending[pending.size() - 1].last_quad = 1;
                    end
                end
                default: ;
            endcase
        endfunction

        function void report(string name, longint e, longint a);
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
            errors++;
        endfunction

        // Compare one quad with the oldest expectation.
        function void check_quad(t_quad a);
            t_quad e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected quad, expected none, actual %h", $time, a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e.quad_valid != a.quad_valid) report("quad_valid", e.quad_valid, a.quad_valid);
            if (e.last_quad != a.last_quad) report("last_quad", e.last_quad, a.last_quad);
            if (e.centre_x != a.centre_x) report("centre_x", e.centre_x, a.centre_x);
            if (e.centre_y != a.centre_y) report("centre_y", e.centre_y, a.centre_y);
            if (e.half_w != a.half_w) report("half_w", e.half_w, a.half_w);
            if (e.half_h != a.half_h) report("half_h", e.half_h, a.half_h);
            if (e.red != a.red) report("red", e.red, a.red);
            if (e.green != a.green) report("green", e.green, a.green);
            if (e.blue != a.blue) report("blue", e.blue, a.blue);
            if (e.alpha != a.alpha) report("alpha", e.alpha, a.alpha);
            if (e.alive_total != a.alive_total)
                report("alive_total", e.alive_total, a.alive_total);
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic start = 0;
    logic busy;
    logic [1:0] i_action = ACT_NONE;
    logic [15:0] i_delta_time = '0;
    logic signed [31:0] i_pos_x = '0, i_pos_y = '0, i_vel_x = '0, i_vel_y = '0;
    logic [23:0] i_life_span = '0;
    logic [31:0] i_size_start = '0, i_size_final = '0;
    logic [31:0] i_colour_start = '0, i_colour_final = '0;
    logic o_result_strobe, o_quad_valid, o_last_quad;
    logic signed [31:0] o_centre_x, o_centre_y;
    logic [15:0] o_half_w, o_half_h;
    logic [7:0] o_red, o_green, o_blue, o_alpha;
    logic [6:0] o_alive_total;

    quad_scoreboard board = new();
    int cycles = 0;
    bit quiet = 0;

    particle_pool_update dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // Sample results and accepted commands at the rising edge.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
        if (i_rst_n && o_result_strobe)
            board.check_quad({o_quad_valid, o_last_quad, o_centre_x, o_centre_y, o_half_w,
                              o_half_h, o_red, o_green, o_blue, o_alpha, o_alive_total});
        if (i_rst_n && start && !busy)
            board.note_command(t_action'(i_action), i_delta_time, i_pos_x, i_pos_y,
                               i_vel_x, i_vel_y, i_life_span, i_size_start,
                               i_size_final, i_colour_start, i_colour_final);
    end

    // Drive one command and hold it until the transfer happens; start drops only
    // for an idle gap, so back-to-back commands keep it high.
    task automatic send(t_action act, logic [15:0] dt, logic [31:0] x, logic [31:0] y,
                        logic [31:0] vxi, logic [31:0] vyi, logic [23:0] life,
                        logic [31:0] s0, logic [31:0] s1, logic [31:0] c0,
                        logic [31:0] c1);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            start <= 0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        i_action <= act;
        i_delta_time <= dt;
        i_pos_x <= x;
        i_pos_y <= y;
        i_vel_x <= vxi;
        i_vel_y <= vyi;
        i_life_span <= life;
        i_size_start <= s0;
        i_size_final <= s1;
        i_colour_start <= c0;
        i_colour_final <= c1;
        start <= 1;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic emit_random();
        logic [23:0] life;
        case ($urandom_range(0, 3))
            0: life = 24'($urandom_range(0, 24'hFFFFFF));
            1: life = 24'($urandom_range(1, 16'hFFFF));
            default: life = 24'($urandom_range(24'h010000, 24'h080000));
        endcase
        send(ACT_EMIT, 16'($urandom), $urandom, $urandom, $urandom, $urandom, life,
             $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic tick(logic [15:0] dt);
        send(ACT_TICK, dt, $urandom, $urandom, $urandom, $urandom, 24'($urandom),
             $urandom, $urandom, $urandom, $urandom);
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: empty tick, extremes, zero lifetime and zero elapsed time.
        tick(16'hFFFF);
        send(ACT_EMIT, '0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
             24'hFFFFFF, 32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF, 32'h00000000);
        send(ACT_EMIT, '0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
             24'h000001, 32'h00000000, 32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF);
        send(ACT_EMIT, '0, 32'h00010000, 32'hFFFF0000, 32'h00008000, 32'hFFFF8000,
             24'h000000, 32'h01000100, 32'h02000200, 32'h11223344, 32'h44332211);
        send(ACT_EMIT, '0, '0, '0, 32'hFFFFFFFF, 32'h00000001, 24'h020000,
             32'h12345678, 32'h9ABCDEF0, 32'hFF00FF00, 32'h00FF00FF);
        tick(16'h0000);
        tick(16'h8000);
        tick(16'hFFFF);
        send(ACT_NONE, 16'hFFFF, $urandom, $urandom, $urandom, $urandom, 24'hFFFFFF,
             $urandom, $urandom, $urandom, $urandom);
        tick(16'h0001);
        send(ACT_CLEAR, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0);
        tick(16'h1234);
        // Fill the pool past its end so the ring wraps.
        repeat (POOL + 3) emit_random();
        tick(16'h0100);
        send(ACT_CLEAR, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0);

        // Random: mostly emits and ticks, some clears and ignored commands.
        for (int k = 0; k < 40; k++) begin
            if (k >= 32) quiet = 1;
            case ($urandom_range(0, 19))
                0: send(ACT_CLEAR, 16'($urandom), $urandom, $urandom, $urandom, $urandom,
                        24'($urandom), $urandom, $urandom, $urandom, $urandom);
                1: send(ACT_NONE, 16'($urandom), $urandom, $urandom, $urandom, $urandom,
                        24'($urandom), $urandom, $urandom, $urandom, $urandom);
                2, 3, 4, 5, 6, 7: tick($urandom_range(0, 3) == 0 ? 16'($urandom)
                                                           : 16'($urandom_range(0, 16'h2000)));
                default: emit_random();
            endcase
        end
        start <= 0;

        // Drain: wait for every expected quad, then a latency margin.
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (1500) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
